FILE: sv/las_pkg.sv
package las_pkg;

  localparam int QueueDepth = 16;
  localparam int PtrW       = $clog2(QueueDepth);
  localparam int CntW       = $clog2(QueueDepth + 1);
  localparam int CfgIdxW    = 4;
  localparam int CfgDataW   = 16;
  localparam int NumAnims   = 5;

  localparam logic [CfgIdxW-1:0] CfgStepTicks = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgIdleTicks = CfgIdxW'(1);

  localparam logic [15:0] StepTicksRst = 16'd1000;
  localparam logic [15:0] IdleTicksRst = 16'd500;

  // Command bytes
  localparam logic [7:0] ByteAnimFirst = 8'd11;
  localparam logic [7:0] ByteAnimLast  = 8'd15;
  localparam logic [7:0] ByteSpeedMin  = 8'd1;
  localparam logic [7:0] ByteSpeedMax  = 8'd3;

  // n/3 for 16-bit n: (n * 0xAAAB) >> 17
  localparam logic [15:0] RecipThree = 16'hAAAB;

  typedef enum logic [2:0] {
    StatTick    = 3'd0,
    StatQueued  = 3'd1,
    StatSpeed   = 3'd2,
    StatUnknown = 3'd3,
    StatDropped = 3'd4
  } status_e;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [5:0] lamps;
    logic [2:0] status;
    logic [4:0] queue_count;
    logic       busy_res;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } ctrl_cmd_t;

  function automatic logic [2:0] anim_len(input logic [2:0] anim);
    logic [2:0] len;
    case (anim)
      3'd0:    len = 3'd7;
      3'd1:    len = 3'd4;
      3'd2:    len = 3'd4;
      3'd3:    len = 3'd3;
      3'd4:    len = 3'd5;
      default: len = 3'd1;
    endcase
    return len;
  endfunction

  function automatic logic [5:0] anim_pat(input logic [2:0] anim, input logic [2:0] step);
    logic [5:0] pat;
    pat = 6'h00;
    case (anim)
      3'd0: begin
        case (step)
          3'd0:    pat = 6'h01;
          3'd2:    pat = 6'h03;
          3'd4:    pat = 6'h07;
          3'd6:    pat = 6'h10;
          default: pat = 6'h00;
        endcase
      end
      3'd1: begin
        case (step)
          3'd0:    pat = 6'h01;
          3'd1:    pat = 6'h03;
          3'd2:    pat = 6'h07;
          3'd3:    pat = 6'h0F;
          default: pat = 6'h00;
        endcase
      end
      3'd2: begin
        case (step)
          3'd0:    pat = 6'h01;
          3'd1:    pat = 6'h02;
          3'd2:    pat = 6'h04;
          3'd3:    pat = 6'h08;
          default: pat = 6'h00;
        endcase
      end
      3'd3: begin
        case (step)
          3'd0:    pat = 6'h08;
          3'd1:    pat = 6'h18;
          3'd2:    pat = 6'h10;
          default: pat = 6'h00;
        endcase
      end
      3'd4: begin
        case (step)
          3'd0:    pat = 6'h08;
          3'd1:    pat = 6'h20;
          3'd2:    pat = 6'h10;
          3'd3:    pat = 6'h28;
          3'd4:    pat = 6'h30;
          default: pat = 6'h00;
        endcase
      end
      default: pat = 6'h00;
    endcase
    return pat;
  endfunction

endpackage

FILE: sv/las_ctrl.sv
module las_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output las_pkg::ctrl_cmd_t cmd_o
);
  import las_pkg::*;

  typedef enum logic [1:0] {
    StLoad = 2'b01,
    StExec = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  // result slot is free if empty or drained this cycle
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    case (state_q)
      StLoad: begin
        in_ready_o  = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = StExec;
        end
      end
      StExec: begin
        if (slot_free) begin
          cmd_o.exec  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = StLoad;
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: sv/las_datapath.sv
module las_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  las_pkg::ctrl_cmd_t            cmd_i,
  input  las_pkg::in_item_t             in_data_i,
  input  logic                          cfg_we_i,
  input  logic [las_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [las_pkg::CfgDataW-1:0]  cfg_data_i,
  output las_pkg::out_item_t            out_data_o
);
  import las_pkg::*;

  in_item_t   in_q;
  out_item_t  out_q, out_d;

  logic [15:0]     step_ticks_q, idle_ticks_q;
  logic [2:0]      pending_q [QueueDepth];
  logic [PtrW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;
  logic [1:0]      divisor_q, divisor_d;
  logic [2:0]      anim_q, anim_d;
  logic [2:0]      step_q, step_d;
  logic [15:0]     time_left_q, time_left_d;
  logic [5:0]      lamp_q, lamp_d;
  logic            playing_q, playing_d;
  logic [15:0]     idle_wait_q, idle_wait_d;
  logic            push;

  logic [31:0] prod3;
  logic [15:0] quot, hold;

  assign prod3 = {16'd0, step_ticks_q} * {16'd0, RecipThree};

  always_comb begin
    case (divisor_q)
      2'd2:    quot = {1'b0, step_ticks_q[15:1]};
      2'd3:    quot = {1'b0, prod3[31:17]};
      default: quot = step_ticks_q;
    endcase
    hold = (quot == 16'd0) ? 16'd1 : quot;
  end

  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    divisor_d   = divisor_q;
    anim_d      = anim_q;
    step_d      = step_q;
    time_left_d = time_left_q;
    lamp_d      = lamp_q;
    playing_d   = playing_q;
    idle_wait_d = idle_wait_q;
    push        = 1'b0;
    out_d       = out_q;
    out_d.status = StatTick;

    if (in_q.cmd) begin
      if (playing_d) begin
        if (time_left_d != 16'd0) begin
          time_left_d = time_left_d - 16'd1;
        end
        if (time_left_d == 16'd0) begin
          step_d = step_d + 3'd1;
          if (step_d >= anim_len(anim_d)) begin
            playing_d = 1'b0;
            lamp_d    = 6'h00;
            step_d    = 3'd0;
          end else begin
            lamp_d      = anim_pat(anim_d, step_d);
            time_left_d = hold;
          end
        end
      end else if (idle_wait_d != 16'd0) begin
        idle_wait_d = idle_wait_d - 16'd1;
      end
      if (!playing_d && idle_wait_d == 16'd0) begin
        if (count_d != '0) begin
          anim_d      = pending_q[head_q];
          head_d      = (head_q == PtrW'(QueueDepth - 1)) ? '0 : head_q + PtrW'(1);
          count_d     = count_d - CntW'(1);
          step_d      = 3'd0;
          playing_d   = 1'b1;
          lamp_d      = anim_pat(anim_d, 3'd0);
          time_left_d = hold;
        end else begin
          idle_wait_d = idle_ticks_q;
        end
      end
    end else if (in_q.rx_byte >= ByteAnimFirst && in_q.rx_byte <= ByteAnimLast) begin
      if (count_q == CntW'(QueueDepth)) begin
        out_d.status = StatDropped;
      end else begin
        push         = 1'b1;
        tail_d       = (tail_q == PtrW'(QueueDepth - 1)) ? '0 : tail_q + PtrW'(1);
        count_d      = count_q + CntW'(1);
        out_d.status = StatQueued;
      end
    end else if (in_q.rx_byte >= ByteSpeedMin && in_q.rx_byte <= ByteSpeedMax) begin
      divisor_d    = in_q.rx_byte[1:0];
      out_d.status = StatSpeed;
    end else begin
      out_d.status = StatUnknown;
    end

    out_d.lamps       = lamp_d;
    out_d.queue_count = 5'(count_d);
    out_d.busy_res    = playing_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_ticks_q <= StepTicksRst;
      idle_ticks_q <= IdleTicksRst;
      head_q       <= '0;
      tail_q       <= '0;
      count_q      <= '0;
      divisor_q    <= 2'd1;
      anim_q       <= 3'd0;
      step_q       <= 3'd0;
      time_left_q  <= 16'd0;
      lamp_q       <= 6'h00;
      playing_q    <= 1'b0;
      idle_wait_q  <= 16'd0;
    end else begin
      if (cfg_we_i && cfg_index_i == CfgStepTicks) begin
        step_ticks_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_index_i == CfgIdleTicks) begin
        idle_ticks_q <= cfg_data_i;
      end
      if (cmd_i.exec) begin
        head_q      <= head_d;
        tail_q      <= tail_d;
        count_q     <= count_d;
        divisor_q   <= divisor_d;
        anim_q      <= anim_d;
        step_q      <= step_d;
        time_left_q <= time_left_d;
        lamp_q      <= lamp_d;
        playing_q   <= playing_d;
        idle_wait_q <= idle_wait_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_q <= in_data_i;
    end
    if (cmd_i.exec) begin
      out_q <= out_d;
    end
    if (cmd_i.exec && push) begin
      pending_q[tail_q] <= 3'(in_q.rx_byte - ByteAnimFirst);
    end
  end

  assign out_data_o = out_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QueueDepth))
    else $error("queue count beyond depth");

  a_play_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    playing_q |-> time_left_q != 16'd0)
    else $error("playing with no hold time left");

  a_dark_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !playing_q |-> lamp_q == 6'h00)
    else $error("lamps lit while not playing");

  a_wait_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idle_wait_q != 16'd0 |-> !playing_q)
    else $error("idle wait running during playback");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && !in_q.cmd |=> head_q == $past(head_q))
    else $error("byte transfer moved queue head");
`endif

endmodule

FILE: sv/led_animation_sequencer_unit.sv
// LED animation sequencer. Each input transfer is either a command byte
// (cmd 0) or one time tick (cmd 1) and yields exactly one result: lamps,
// status, queue_count and busy_res as they stand after the item. Bytes 11
// to 15 queue an animation in a 16-entry ring FIFO, bytes 1 to 3 set the
// speed divisor; ticks advance the player. An item is first captured
// into the input register, then applied in the state update, which
// waits while the output register still holds an untaken result. A new
// item is accepted only once the previous one has been applied. The
// divide by three of the step hold is a reciprocal multiply in the update
// cycle. Configuration writes (index 0 step_ticks, 1 idle_ticks, others
// ignored) are taken every cycle.
module led_animation_sequencer_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  las_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output las_pkg::out_item_t            out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [las_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [las_pkg::CfgDataW-1:0]  cfg_data_i
);
  import las_pkg::*;

  ctrl_cmd_t ctrl_cmd;
  logic      cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  las_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (ctrl_cmd)
  );

  las_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (ctrl_cmd),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_data_o  (out_data_o)
  );

endmodule
